>>> rtl/core/pbs_pkg.sv
// Shared types and constants for the priority batch scheduler.
// No dependencies; every other file of the block refers to this package.
package pbs_pkg;

    localparam int PRIO_W  = 16;
    localparam int TAG_W   = 16;
    localparam int SIZE_W  = 16;
    localparam int LIMIT_W = 24;
    localparam int SUM_W   = 25;

    // operation codes of an input item
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_END    = 1'b1;

    // command from the front to the back: optional flush, then optional insert
    typedef struct packed {
        logic                     flush;
        logic                     final_flag;
        logic                     insert;
        logic signed [PRIO_W-1:0] prio;
        logic        [TAG_W-1:0]  tag;
    } t_cmd;

endpackage

>>> rtl/core/pbs_in_if.sv
// Input packet channel of the priority batch scheduler.
// Depends on pbs_pkg for field widths.
interface pbs_in_if;
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic signed [pbs_pkg::PRIO_W-1:0] priority_req;
    logic        [pbs_pkg::SIZE_W-1:0] packet_size;
    logic        [pbs_pkg::TAG_W-1:0]  packet_tag;

    modport source (output valid, operation, priority_req, packet_size, packet_tag,
                    input ready);
    modport sink (input valid, operation, priority_req, packet_size, packet_tag,
                  output ready);
endinterface

>>> rtl/core/pbs_out_if.sv
// Result channel of the priority batch scheduler.
// Depends on pbs_pkg for field widths.
interface pbs_out_if;
    logic                             valid;
    logic                             ready;
    logic        [pbs_pkg::TAG_W-1:0]  out_tag;
    logic signed [pbs_pkg::PRIO_W-1:0] out_priority;
    logic                             last_in_batch;
    logic                             final_batch;

    modport source (output valid, out_tag, out_priority, last_in_batch, final_batch,
                    input ready);
    modport sink (input valid, out_tag, out_priority, last_in_batch, final_batch,
                  output ready);
endinterface

>>> rtl/core/pbs_cfg_if.sv
// Configuration write channel of the priority batch scheduler (size limit).
// Depends on pbs_pkg for the register width.
interface pbs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pbs_pkg::LIMIT_W-1:0]       size_limit;

    modport source (output valid, size_limit, input ready);
    modport sink (input valid, size_limit, output ready);
endinterface

>>> rtl/core/pbs_front.sv
// Front end: accepts packet items, tracks queue fill and size sum, decides
// flushes and pushes commands into a two-entry command queue. Uses pbs_pkg.
module pbs_front #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pbs_in_if.sink                        i_pkt,
    input  logic [pbs_pkg::LIMIT_W-1:0]   i_size_limit,
    output logic                          o_cmd_valid,
    output pbs_pkg::t_cmd                 o_cmd,
    input  logic                          i_cmd_ready
);

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int FIFO_D = 2;

    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [pbs_pkg::SUM_W-1:0]     r_sum, n_sum;
    pbs_pkg::t_cmd                 r_fifo [FIFO_D];
    logic                          r_wr_ptr, r_rd_ptr;
    logic [1:0]                    r_fill;

    logic                          w_accept, w_pop, w_push;
    logic [pbs_pkg::SUM_W:0]       w_total;
    logic                          w_over, w_full, w_nonempty;
    pbs_pkg::t_cmd                 w_cmd;

    assign i_pkt.ready = (r_fill != 2'(FIFO_D));
    assign w_accept    = i_pkt.valid && i_pkt.ready;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_fifo[r_rd_ptr];
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    assign w_total    = {1'b0, r_sum} + (pbs_pkg::SUM_W + 1)'(i_pkt.packet_size);
    assign w_over     = w_total > (pbs_pkg::SUM_W + 1)'(i_size_limit);
    assign w_full     = r_cnt >= CNT_W'(QUEUE_DEPTH);
    assign w_nonempty = r_cnt != '0;

    // classify the item against the queue as it will stand when the back runs it
    always_comb begin
        w_cmd.flush      = 1'b0;
        w_cmd.final_flag = 1'b0;
        w_cmd.insert     = 1'b0;
        w_cmd.prio       = i_pkt.priority_req;
        w_cmd.tag        = i_pkt.packet_tag;
        w_push           = 1'b0;
        n_cnt            = r_cnt;
        n_sum            = r_sum;
        case (i_pkt.operation)
            pbs_pkg::OP_INSERT: begin
                w_cmd.flush  = (w_nonempty && w_over) || w_full;
                w_cmd.insert = 1'b1;
                w_push       = 1'b1;
                if (w_cmd.flush) begin
                    n_cnt = CNT_W'(1);
                    n_sum = pbs_pkg::SUM_W'(i_pkt.packet_size);
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                    n_sum = w_total[pbs_pkg::SUM_W-1:0];
                end
            end
            pbs_pkg::OP_END: begin
                // drop an end on an empty queue
                w_cmd.flush      = w_nonempty;
                w_cmd.final_flag = 1'b1;
                w_push           = w_nonempty;
                n_cnt            = '0;
                n_sum            = '0;
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_sum    <= '0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_accept) begin
                r_cnt <= n_cnt;
                r_sum <= n_sum;
            end
            if (w_accept && w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_fill <= r_fill + 2'(w_accept && w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_push) begin
            r_fifo[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

>>> rtl/core/pbs_back.sv
// Back end: holds the sorted entry queue, inserts in place and drains flushes
// one item per cycle into the free result register. Uses pbs_pkg, pbs_out_if.
module pbs_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  pbs_pkg::t_cmd i_cmd,
    output logic          o_cmd_ready,
    pbs_out_if.source     o_res
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } t_state;

    t_state                              r_state, n_state;
    logic [CNT_W-1:0]                    r_cnt, n_cnt;
    pbs_pkg::t_cmd                       r_pend, n_pend;
    logic signed [pbs_pkg::PRIO_W-1:0]   r_prio [QUEUE_DEPTH];
    logic signed [pbs_pkg::PRIO_W-1:0]   n_prio [QUEUE_DEPTH];
    logic        [pbs_pkg::TAG_W-1:0]    r_tag  [QUEUE_DEPTH];
    logic        [pbs_pkg::TAG_W-1:0]    n_tag  [QUEUE_DEPTH];

    logic                                r_out_valid, n_out_valid;
    logic        [pbs_pkg::TAG_W-1:0]    r_out_tag, n_out_tag;
    logic signed [pbs_pkg::PRIO_W-1:0]   r_out_prio, n_out_prio;
    logic                                r_out_last, n_out_last;
    logic                                r_out_final, n_out_final;

    logic                                w_out_free;
    logic [QUEUE_DEPTH-1:0]              w_ge;

    assign o_cmd_ready         = (r_state == ST_IDLE);
    assign w_out_free          = !r_out_valid || o_res.ready;
    assign o_res.valid         = r_out_valid;
    assign o_res.out_tag       = r_out_tag;
    assign o_res.out_priority  = r_out_prio;
    assign o_res.last_in_batch = r_out_last;
    assign o_res.final_batch   = r_out_final;

    // entries that stay ahead of the new one; a prefix since the queue is sorted
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_ge[i] = (CNT_W'(i) < r_cnt) && (r_prio[i] >= i_cmd.prio);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_prio      = r_prio;
        n_tag       = r_tag;
        n_out_valid = r_out_valid;
        n_out_tag   = r_out_tag;
        n_out_prio  = r_out_prio;
        n_out_last  = r_out_last;
        n_out_final = r_out_final;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.flush) begin
                        n_state = ST_FLUSH;
                        n_pend  = i_cmd;
                    end else if (i_cmd.insert) begin
                        if (!w_ge[0]) begin
                            n_prio[0] = i_cmd.prio;
                            n_tag[0]  = i_cmd.tag;
                        end
                        for (int i = 1; i < QUEUE_DEPTH; i++) begin
                            if (!w_ge[i]) begin
                                if (w_ge[i-1]) begin
                                    n_prio[i] = i_cmd.prio;
                                    n_tag[i]  = i_cmd.tag;
                                end else begin
                                    n_prio[i] = r_prio[i-1];
                                    n_tag[i]  = r_tag[i-1];
                                end
                            end
                        end
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    // emit the head and advance the queue by one
                    n_out_valid = 1'b1;
                    n_out_tag   = r_tag[0];
                    n_out_prio  = r_prio[0];
                    n_out_last  = (r_cnt == CNT_W'(1));
                    n_out_final = r_pend.final_flag;
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                        n_prio[i] = r_prio[i+1];
                        n_tag[i]  = r_tag[i+1];
                    end
                    n_cnt = r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                        // the queue is now empty: the held insert lands at the head
                        if (r_pend.insert) begin
                            n_prio[0] = r_pend.prio;
                            n_tag[0]  = r_pend.tag;
                            n_cnt     = CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_pend      <= n_pend;
        r_out_tag   <= n_out_tag;
        r_out_prio  <= n_out_prio;
        r_out_last  <= n_out_last;
        r_out_final <= n_out_final;
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_tag  <= n_tag;
    end

endmodule

>>> rtl/core/priority_batch_scheduler.sv
// Priority batch scheduler: top level with the size-limit register.
// Depends on pbs_pkg, the three channel interfaces, pbs_front and pbs_back.
//
// Packets are kept sorted by descending priority (ties in arrival order) and
// flushed as a batch when the next packet would push the size sum past the
// limit, when the queue already holds QUEUE_DEPTH packets, or on an end item.
// The front accepts one item per cycle while its two-entry command queue has
// room; the back retires an insert through a parallel compare-and-shift over
// all queue entries. A flush in the back first takes the command, then emits
// one result per cycle through the single result register while that register
// is free. The insert that caused it completes in the same cycle as the last
// result. A stalled result channel holds the back, and the front fills its
// queue and then holds the input. The user must write the size limit only
// while the block is idle; the block itself does not enforce it.
module priority_batch_scheduler #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pbs_in_if.sink    i_pkt,
    pbs_cfg_if.sink   i_cfg,
    pbs_out_if.source o_res
);

    logic [pbs_pkg::LIMIT_W-1:0] r_size_limit;
    logic                        w_cmd_valid;
    logic                        w_cmd_ready;
    pbs_pkg::t_cmd               w_cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_limit <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_size_limit <= i_cfg.size_limit;
        end
    end

    pbs_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pkt        (i_pkt),
        .i_size_limit (r_size_limit),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_ready  (w_cmd_ready)
    );

    pbs_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_res       (o_res)
    );

endmodule
